// ===== rtl/bfmt_pkg.sv =====
package bfmt_pkg;

  localparam int TableEntriesDefault = 1024;
  localparam int SlotW = 10;
  localparam logic [15:0] EtherIpv4 = 16'h0800;
  localparam logic [7:0] ProtoTcp = 8'd6;
  localparam logic [7:0] ProtoUdp = 8'd17;

  // request codes
  typedef enum logic [1:0] {
    ACT_EGRESS  = 2'd0,
    ACT_INGRESS = 2'd1,
    ACT_READ    = 2'd2,
    ACT_NONE    = 2'd3
  } action_t;

  // result status codes
  typedef enum logic [2:0] {
    ST_FILTERED   = 3'd0,
    ST_EG_NEW     = 3'd1,
    ST_EG_UPDATE  = 3'd2,
    ST_FULL       = 3'd3,
    ST_IN_UPDATE  = 3'd4,
    ST_IN_MISS    = 3'd5,
    ST_READ_VALID = 3'd6,
    ST_READ_EMPTY = 3'd7
  } status_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SCAN,
    S_WAIT,
    S_WRITE,
    S_RESP,
    S_OUT
  } state_t;

  // commands from controller to datapath
  typedef struct packed {
    logic    load;       // capture request
    logic    scan_start; // reset scan pointer
    logic    scan_step;  // advance scan pointer
    logic    rd_hit;     // read entry at match slot
    logic    rd_req;     // read entry at read_slot
    logic    write;      // write updated entry
    logic    result;     // build result into output register
    status_t status;
  } bfmt_cmd_t;

  // status from datapath to controller
  typedef struct packed {
    action_t action;
    logic    tracked;
    logic    scan_done;
    logic    hit;
    logic    free_found;
    logic    rd_valid;
  } bfmt_sts_t;

endpackage

// ===== rtl/bidirectional_flow_meter_table.sv =====
// A filtered request goes from the request register straight to the result; a slot
// read reads the entry first; a packet runs a linear key scan, one slot per cycle,
// until a match or the table end, then reads the entry, writes it on a hit or a free
// egress slot and builds the result. One request in flight: the next is accepted
// after the result register loads, and output stalls hold that load back.
// Synchronous active-low reset clears the control state and all slot valid bits.
module bidirectional_flow_meter_table #(
  parameter int TABLE_ENTRIES = bfmt_pkg::TableEntriesDefault
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  // action, headers_ok, ether_type, ip_protocol, pkt_src_ip, pkt_dst_ip,
  // pkt_src_port, pkt_dst_port, packet_length, now_ns, read_slot
  input  logic [215:0] in_tdata,
  output logic         out_tvalid,
  input  logic         out_tready,
  // status, slot, flow_src_ip, flow_dst_ip, flow_ports, flow_protocol,
  // sent_bytes, received_bytes, sent_packets, received_packets,
  // first_seen_ns, last_pkt_ns
  output logic [423:0] out_tdata
);
  import bfmt_pkg::*;

  bfmt_cmd_t    cmd;
  bfmt_sts_t    sts;

  bfmt_ctrl u_ctrl (
    .clk, .rst_n, .in_tvalid, .in_tready, .out_tvalid, .out_tready,
    .sts, .cmd
  );

  bfmt_dp #(.TableEntries(TABLE_ENTRIES)) u_dp (
    .clk, .rst_n,
    .in_tdata,
    .cmd, .sts,
    .out_tdata
  );

endmodule

// ===== rtl/bfmt_ctrl.sv =====
module bfmt_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_tvalid,
  output logic              in_tready,
  output logic              out_tvalid,
  input  logic              out_tready,
  input  bfmt_pkg::bfmt_sts_t sts,
  output bfmt_pkg::bfmt_cmd_t cmd
);
  import bfmt_pkg::*;

  state_t state_r, state_nxt;
  logic   ovalid_r, ovalid_nxt;

  // state and output valid registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= S_IDLE;
      ovalid_r <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      ovalid_r <= ovalid_nxt;
    end
  end

  assign in_tready  = (state_r == S_IDLE);
  assign out_tvalid = ovalid_r;

  // next state and commands
  always_comb begin
    state_nxt  = state_r;
    ovalid_nxt = ovalid_r;
    cmd        = '0;
    cmd.status = ST_FILTERED;
    if (ovalid_r && out_tready) ovalid_nxt = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        if (in_tvalid) begin
          cmd.load       = 1'b1;
          cmd.scan_start = 1'b1;
          state_nxt      = S_SCAN;
        end
      end
      S_SCAN: begin
        if (sts.action == ACT_READ) begin
          cmd.rd_req = 1'b1;
          state_nxt  = S_WAIT;
        end else if (!sts.tracked) begin
          state_nxt = S_RESP;
        end else if (sts.hit || sts.scan_done) begin
          cmd.rd_hit = 1'b1;
          state_nxt  = S_WAIT;
        end else begin
          cmd.scan_step = 1'b1;
        end
      end
      S_WAIT: begin
        if (sts.action == ACT_READ) state_nxt = S_RESP;
        else state_nxt = S_WRITE;
      end
      S_WRITE: begin
        if (sts.hit || (sts.action == ACT_EGRESS && sts.free_found))
          cmd.write = 1'b1;
        state_nxt = S_RESP;
      end
      S_RESP: begin
        if (!ovalid_r || out_tready) begin
          cmd.result = 1'b1;
          ovalid_nxt = 1'b1;
          state_nxt  = S_IDLE;
          if (sts.action == ACT_READ)
            cmd.status = sts.rd_valid ? ST_READ_VALID : ST_READ_EMPTY;
          else if (!sts.tracked)
            cmd.status = ST_FILTERED;
          else if (sts.action == ACT_EGRESS)
            cmd.status = sts.hit ? ST_EG_UPDATE :
                         (sts.free_found ? ST_EG_NEW : ST_FULL);
          else
            cmd.status = sts.hit ? ST_IN_UPDATE : ST_IN_MISS;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // a result is only built while the output register is free
  a_res_free: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.result |-> (!ovalid_r || out_tready)) else $error("result overwrite");
  // input is taken only in idle
  a_load_idle: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.load |-> state_r == S_IDLE) else $error("load outside idle");
  // a write follows the entry read
  a_write_seq: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.write |-> $past(state_r) == S_WAIT) else $error("write out of order");

endmodule

// ===== rtl/bfmt_dp.sv =====
module bfmt_dp #(
  parameter int TableEntries = bfmt_pkg::TableEntriesDefault,
  parameter int IdxW = $clog2(TableEntries)
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic [215:0]         in_tdata,
  input  bfmt_pkg::bfmt_cmd_t  cmd,
  output bfmt_pkg::bfmt_sts_t  sts,
  output logic [423:0]         out_tdata
);
  import bfmt_pkg::*;

  localparam int CntW = IdxW + 1;

  // key, counter and timestamp memories, TableEntries deep, one field each
  logic [63:0]  mem_addr  [TableEntries];
  logic [39:0]  mem_ppp   [TableEntries];
  logic [47:0]  mem_bout  [TableEntries];
  logic [47:0]  mem_bin   [TableEntries];
  logic [39:0]  mem_pout  [TableEntries];
  logic [39:0]  mem_pin   [TableEntries];
  logic [63:0]  mem_first [TableEntries];
  logic [63:0]  mem_last  [TableEntries];
  logic [TableEntries-1:0] valid_r;

  // request register
  logic [1:0]  act_r;
  logic        tracked_r;
  logic [63:0] key_addr_r;
  logic [39:0] key_ppp_r;
  logic [15:0] len_r;
  logic [63:0] now_r;
  logic [9:0]  rslot_r;

  // scan state
  logic [CntW-1:0] scan_r;
  logic            hit_r, free_r, rdv_r;
  logic [IdxW-1:0] hit_slot_r, free_slot_r, tgt_r;

  // entry read registers
  logic [63:0] ent_addr_r, ent_first_r, ent_last_r;
  logic [39:0] ent_ppp_r, ent_pout_r, ent_pin_r;
  logic [47:0] ent_bout_r, ent_bin_r;

  logic [IdxW-1:0] scan_idx;
  logic [63:0]     scan_addr_r;
  logic [39:0]     scan_ppp_r;
  logic            s_match;
  logic            ok;
  logic [1:0]      act_in;
  logic [7:0]      proto_in;
  logic [31:0]     sip, dip;
  logic [15:0]     sp, dp;

  assign act_in   = in_tdata[1:0];
  assign proto_in = in_tdata[26:19];
  assign sip      = in_tdata[58:27];
  assign dip      = in_tdata[90:59];
  assign sp       = in_tdata[106:91];
  assign dp       = in_tdata[122:107];
  assign ok = in_tdata[2] && (in_tdata[18:3] == EtherIpv4) &&
              ((proto_in == ProtoTcp) || (proto_in == ProtoUdp)) &&
              (act_in == ACT_EGRESS || act_in == ACT_INGRESS);

  assign scan_idx = scan_r[IdxW-1:0];

  // capture request, reversing the key for ingress
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      act_r     <= act_in;
      tracked_r <= ok;
      len_r     <= in_tdata[138:123];
      now_r     <= in_tdata[202:139];
      rslot_r   <= in_tdata[212:203];
      if (act_in == ACT_INGRESS) begin
        key_addr_r <= {dip, sip};
        key_ppp_r  <= {dp, sp, proto_in};
      end else begin
        key_addr_r <= {sip, dip};
        key_ppp_r  <= {sp, dp, proto_in};
      end
    end
  end

  // key read for the scan, one slot per cycle
  always_ff @(posedge clk) begin
    scan_addr_r <= mem_addr[scan_idx];
    scan_ppp_r  <= mem_ppp[scan_idx];
  end

  logic [CntW-1:0] cmp_r;
  logic            cmp_v_r;
  assign s_match = cmp_v_r && valid_r[cmp_r[IdxW-1:0]] &&
                   scan_addr_r == key_addr_r && scan_ppp_r == key_ppp_r;

  // scan pointer; the compare uses the registered key read of the previous pointer value
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      scan_r <= '0; cmp_v_r <= 1'b0; hit_r <= 1'b0; free_r <= 1'b0;
    end else if (cmd.scan_start) begin
      scan_r <= '0; cmp_v_r <= 1'b0; hit_r <= 1'b0; free_r <= 1'b0;
    end else if (cmd.scan_step) begin
      if (scan_r < CntW'(TableEntries)) scan_r <= scan_r + CntW'(1);
      cmp_r   <= scan_r;
      cmp_v_r <= (scan_r < CntW'(TableEntries));
      if (s_match) begin
        hit_r <= 1'b1; hit_slot_r <= cmp_r[IdxW-1:0];
      end
      if (cmp_v_r && !free_r && !valid_r[cmp_r[IdxW-1:0]]) begin
        free_r <= 1'b1; free_slot_r <= cmp_r[IdxW-1:0];
      end
    end else if (cmd.rd_hit && s_match) begin
      hit_r <= 1'b1; hit_slot_r <= cmp_r[IdxW-1:0];
    end
  end

  logic done_c;
  assign done_c = !cmp_v_r && (scan_r == CntW'(TableEntries));

  assign sts.action     = action_t'(act_r);
  assign sts.tracked    = tracked_r;
  assign sts.hit        = hit_r || s_match;
  assign sts.scan_done  = done_c;
  assign sts.free_found = free_r;
  assign sts.rd_valid   = rdv_r;

  logic [IdxW-1:0] rd_idx;
  always_comb begin
    if (cmd.rd_req) rd_idx = IdxW'(rslot_r);
    else if (s_match) rd_idx = cmp_r[IdxW-1:0];
    else rd_idx = hit_slot_r;
  end

  // entry read
  always_ff @(posedge clk) begin
    if (cmd.rd_req || cmd.rd_hit) begin
      ent_addr_r  <= mem_addr[rd_idx];
      ent_ppp_r   <= mem_ppp[rd_idx];
      ent_bout_r  <= mem_bout[rd_idx];
      ent_bin_r   <= mem_bin[rd_idx];
      ent_pout_r  <= mem_pout[rd_idx];
      ent_pin_r   <= mem_pin[rd_idx];
      ent_first_r <= mem_first[rd_idx];
      ent_last_r  <= mem_last[rd_idx];
      tgt_r       <= (cmd.rd_hit && !hit_r && !s_match) ? free_slot_r : rd_idx;
      rdv_r       <= (32'(rslot_r) < TableEntries) && valid_r[rd_idx];
    end
  end

  // counter updates: saturating on a hit, fresh counters for a new flow
  logic [48:0] bsum;
  logic [40:0] psum;
  logic [47:0] bout_n, bin_n;
  logic [39:0] pout_n, pin_n;
  logic [63:0] first_n;
  logic        is_eg;
  assign is_eg = (act_r == ACT_EGRESS);
  assign bsum  = {1'b0, is_eg ? ent_bout_r : ent_bin_r} + {33'd0, len_r};
  assign psum  = {1'b0, is_eg ? ent_pout_r : ent_pin_r} + 41'd1;
  always_comb begin
    bout_n = ent_bout_r; bin_n = ent_bin_r; pout_n = ent_pout_r; pin_n = ent_pin_r;
    first_n = ent_first_r;
    if (!hit_r) begin
      bout_n = {32'd0, len_r}; bin_n = '0; pout_n = 40'd1; pin_n = '0;
      first_n = now_r;
    end else if (is_eg) begin
      bout_n = bsum[48] ? '1 : bsum[47:0];
      pout_n = psum[40] ? '1 : psum[39:0];
    end else begin
      bin_n = bsum[48] ? '1 : bsum[47:0];
      pin_n = psum[40] ? '1 : psum[39:0];
    end
  end

  // write back; separate registers keep the new entry for the result
  always_ff @(posedge clk) begin
    if (cmd.write) begin
      mem_addr[tgt_r]  <= key_addr_r;
      mem_ppp[tgt_r]   <= key_ppp_r;
      mem_bout[tgt_r]  <= bout_n;
      mem_bin[tgt_r]   <= bin_n;
      mem_pout[tgt_r]  <= pout_n;
      mem_pin[tgt_r]   <= pin_n;
      mem_first[tgt_r] <= first_n;
      mem_last[tgt_r]  <= now_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) valid_r <= '0;
    else if (cmd.write) valid_r[tgt_r] <= 1'b1;
  end

  logic [47:0] new_bout_r, new_bin_r;
  logic [39:0] new_pout_r, new_pin_r;
  logic [63:0] new_first_r, new_last_r;
  logic        wrote_r;
  always_ff @(posedge clk) begin
    if (!rst_n) wrote_r <= 1'b0;
    else if (cmd.load) wrote_r <= 1'b0;
    else if (cmd.write) wrote_r <= 1'b1;
    if (cmd.write) begin
      new_bout_r <= bout_n; new_bin_r <= bin_n; new_pout_r <= pout_n; new_pin_r <= pin_n;
      new_first_r <= first_n; new_last_r <= now_r;
    end
  end

  // result register
  logic show_entry, show_key;
  assign show_entry = (cmd.status == ST_EG_NEW) || (cmd.status == ST_EG_UPDATE) ||
                      (cmd.status == ST_IN_UPDATE) || (cmd.status == ST_READ_VALID);
  assign show_key   = (cmd.status == ST_FULL) || (cmd.status == ST_IN_MISS);

  logic [423:0] res_nxt;
  always_comb begin
    res_nxt = '0;
    res_nxt[2:0] = cmd.status;
    if (cmd.status == ST_READ_EMPTY) res_nxt[12:3] = rslot_r;
    if (show_key) begin
      res_nxt[44:13]   = key_addr_r[63:32];
      res_nxt[76:45]   = key_addr_r[31:0];
      res_nxt[108:77]  = key_ppp_r[39:8];
      res_nxt[116:109] = key_ppp_r[7:0];
    end
    if (show_entry) begin
      res_nxt[12:3]    = 10'(tgt_r);
      res_nxt[44:13]   = wrote_r ? key_addr_r[63:32] : ent_addr_r[63:32];
      res_nxt[76:45]   = wrote_r ? key_addr_r[31:0] : ent_addr_r[31:0];
      res_nxt[108:77]  = wrote_r ? key_ppp_r[39:8] : ent_ppp_r[39:8];
      res_nxt[116:109] = wrote_r ? key_ppp_r[7:0] : ent_ppp_r[7:0];
      res_nxt[164:117] = wrote_r ? new_bout_r : ent_bout_r;
      res_nxt[212:165] = wrote_r ? new_bin_r : ent_bin_r;
      res_nxt[252:213] = wrote_r ? new_pout_r : ent_pout_r;
      res_nxt[292:253] = wrote_r ? new_pin_r : ent_pin_r;
      res_nxt[356:293] = wrote_r ? new_first_r : ent_first_r;
      res_nxt[420:357] = wrote_r ? new_last_r : ent_last_r;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.result) out_tdata <= res_nxt;
  end

  // a write target is a valid hit or a free slot
  a_wr_tgt: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.write |-> (hit_r || !valid_r[tgt_r])) else $error("bad write target");
  // scan never advances past the table
  a_scan_rng: assert property (@(posedge clk) disable iff (!rst_n)
    scan_r <= CntW'(TableEntries)) else $error("scan overrun");
  // the free-slot flag once set stays set until a write or a new scan
  a_free_ok: assert property (@(posedge clk) disable iff (!rst_n)
    (free_r && !cmd.write && !cmd.scan_start) |=> free_r || $past(cmd.scan_start))
    else $error("free slot lost");

endmodule

// ===== bench/flow_tb_pkg.sv =====
package flow_tb_pkg;
  import bfmt_pkg::*;

  localparam int FlowSlots = 1024;

  // one request on in_tdata; field order runs from the top bit down
  typedef struct packed {
    logic [2:0]  pad;
    logic [9:0]  read_slot;
    logic [63:0] now_ns;
    logic [15:0] packet_length;
    logic [15:0] pkt_dst_port;
    logic [15:0] pkt_src_port;
    logic [31:0] pkt_dst_ip;
    logic [31:0] pkt_src_ip;
    logic [7:0]  ip_protocol;
    logic [15:0] ether_type;
    logic        headers_ok;
    action_t     action;
  } flow_req_t;

  // one result on out_tdata
  typedef struct packed {
    logic [2:0]  pad;
    logic [63:0] last_pkt_ns;
    logic [63:0] first_seen_ns;
    logic [39:0] received_packets;
    logic [39:0] sent_packets;
    logic [47:0] received_bytes;
    logic [47:0] sent_bytes;
    logic [7:0]  flow_protocol;
    logic [31:0] flow_ports;
    logic [31:0] flow_dst_ip;
    logic [31:0] flow_src_ip;
    logic [9:0]  slot;
    status_t     status;
  } flow_rsp_t;

endpackage

// ===== bench/flow_meter_checker.sv =====
module flow_meter_checker (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  input  logic         in_tready,
  input  logic [215:0] in_tdata,
  input  logic         out_tvalid,
  input  logic         out_tready,
  input  logic [423:0] out_tdata,
  output int           fail_count,
  output int           pending
);
  timeunit 1ns;
  timeprecision 1ps;
  import bfmt_pkg::*;
  import flow_tb_pkg::*;

  // shadow flow table
  bit          tbl_valid [FlowSlots];
  logic [63:0] tbl_addr [FlowSlots];
  logic [39:0] tbl_key [FlowSlots];
  logic [47:0] tbl_tx_bytes [FlowSlots];
  logic [47:0] tbl_rx_bytes [FlowSlots];
  logic [39:0] tbl_tx_pkts [FlowSlots];
  logic [39:0] tbl_rx_pkts [FlowSlots];
  logic [63:0] tbl_first [FlowSlots];
  logic [63:0] tbl_last [FlowSlots];

  flow_rsp_t expected_rsp_q[$];

  initial begin
    fail_count = 0;
    pending = 0;
    foreach (tbl_valid[i]) tbl_valid[i] = 1'b0;
  end

  function automatic logic [47:0] sat_bytes(logic [47:0] a, logic [15:0] b);
    logic [48:0] sum;
    sum = {1'b0, a} + {33'd0, b};
    return sum[48] ? '1 : sum[47:0];
  endfunction

  function automatic logic [39:0] sat_pkts(logic [39:0] a);
    return (a == '1) ? a : a + 40'd1;
  endfunction

  function automatic flow_rsp_t key_fields(logic [63:0] addr, logic [39:0] key);
    flow_rsp_t o;
    o = '0;
    o.flow_src_ip = addr[63:32];
    o.flow_dst_ip = addr[31:0];
    o.flow_ports = key[39:8];
    o.flow_protocol = key[7:0];
    return o;
  endfunction

  function automatic flow_rsp_t slot_entry(int s, status_t st);
    flow_rsp_t o;
    o = key_fields(tbl_addr[s], tbl_key[s]);
    o.status = st;
    o.slot = s[9:0];
    o.sent_bytes = tbl_tx_bytes[s];
    o.received_bytes = tbl_rx_bytes[s];
    o.sent_packets = tbl_tx_pkts[s];
    o.received_packets = tbl_rx_pkts[s];
    o.first_seen_ns = tbl_first[s];
    o.last_pkt_ns = tbl_last[s];
    return o;
  endfunction

  function automatic int lookup_flow(logic [63:0] addr, logic [39:0] key);
    for (int s = 0; s < FlowSlots; s++) begin
      if (tbl_valid[s] && tbl_addr[s] == addr && tbl_key[s] == key) return s;
    end
    return -1;
  endfunction

  // apply one request to the shadow table and return the result it causes
  function automatic flow_rsp_t meter_update(flow_req_t r);
    flow_rsp_t o;
    logic [63:0] addr;
    logic [39:0] key;
    int s;
    bit tracked;
    o = '0;
    tracked = r.headers_ok && r.ether_type == EtherIpv4 &&
              (r.ip_protocol == ProtoTcp || r.ip_protocol == ProtoUdp);
    case (r.action)
      ACT_READ: begin
        if (tbl_valid[r.read_slot]) begin
          o = slot_entry(int'(r.read_slot), ST_READ_VALID);
        end else begin
          o.status = ST_READ_EMPTY;
          o.slot = r.read_slot;
        end
      end
      ACT_EGRESS: begin
        if (tracked) begin
          addr = {r.pkt_src_ip, r.pkt_dst_ip};
          key = {r.pkt_src_port, r.pkt_dst_port, r.ip_protocol};
          s = lookup_flow(addr, key);
          if (s >= 0) begin
            tbl_tx_bytes[s] = sat_bytes(tbl_tx_bytes[s], r.packet_length);
            tbl_tx_pkts[s] = sat_pkts(tbl_tx_pkts[s]);
            tbl_last[s] = r.now_ns;
            o = slot_entry(s, ST_EG_UPDATE);
          end else begin
            s = 0;
            while (s < FlowSlots && tbl_valid[s]) s++;
            if (s == FlowSlots) begin
              o = key_fields(addr, key);
              o.status = ST_FULL;
            end else begin
              tbl_valid[s] = 1'b1;
              tbl_addr[s] = addr;
              tbl_key[s] = key;
              tbl_tx_bytes[s] = {32'd0, r.packet_length};
              tbl_rx_bytes[s] = '0;
              tbl_tx_pkts[s] = 40'd1;
              tbl_rx_pkts[s] = '0;
              tbl_first[s] = r.now_ns;
              tbl_last[s] = r.now_ns;
              o = slot_entry(s, ST_EG_NEW);
            end
          end
        end
      end
      ACT_INGRESS: begin
        if (tracked) begin
          // reply direction: swap ends to get the egress key
          addr = {r.pkt_dst_ip, r.pkt_src_ip};
          key = {r.pkt_dst_port, r.pkt_src_port, r.ip_protocol};
          s = lookup_flow(addr, key);
          if (s >= 0) begin
            tbl_rx_bytes[s] = sat_bytes(tbl_rx_bytes[s], r.packet_length);
            tbl_rx_pkts[s] = sat_pkts(tbl_rx_pkts[s]);
            tbl_last[s] = r.now_ns;
            o = slot_entry(s, ST_IN_UPDATE);
          end else begin
            o = key_fields(addr, key);
            o.status = ST_IN_MISS;
          end
        end
      end
      default: o = '0;
    endcase
    return o;
  endfunction

  task automatic check_field(string name, logic [63:0] exp_v, logic [63:0] act_v);
    if (exp_v !== act_v) begin
      $error("%s mismatch: expected 0x%0h, got 0x%0h", name, exp_v, act_v);
      fail_count++;
    end
  endtask

  // predict on each request transfer, compare on each result transfer
  always @(posedge clk) begin
    flow_rsp_t exp_r;
    flow_rsp_t got;
    if (rst_n) begin
      if (in_tvalid && in_tready) expected_rsp_q.push_back(meter_update(flow_req_t'(in_tdata)));
      if (out_tvalid && out_tready) begin
        got = flow_rsp_t'(out_tdata);
        if (expected_rsp_q.size() == 0) begin
          $error("result transfer with no request outstanding");
          fail_count++;
        end else begin
          exp_r = expected_rsp_q.pop_front();
          check_field("status", 64'(exp_r.status), 64'(got.status));
          check_field("slot", 64'(exp_r.slot), 64'(got.slot));
          check_field("flow_src_ip", 64'(exp_r.flow_src_ip), 64'(got.flow_src_ip));
          check_field("flow_dst_ip", 64'(exp_r.flow_dst_ip), 64'(got.flow_dst_ip));
          check_field("flow_ports", 64'(exp_r.flow_ports), 64'(got.flow_ports));
          check_field("flow_protocol", 64'(exp_r.flow_protocol), 64'(got.flow_protocol));
          check_field("sent_bytes", 64'(exp_r.sent_bytes), 64'(got.sent_bytes));
          check_field("received_bytes", 64'(exp_r.received_bytes),
                      64'(got.received_bytes));
          check_field("sent_packets", 64'(exp_r.sent_packets), 64'(got.sent_packets));
          check_field("received_packets", 64'(exp_r.received_packets),
                      64'(got.received_packets));
          check_field("first_seen_ns", exp_r.first_seen_ns, got.first_seen_ns);
          check_field("last_pkt_ns", exp_r.last_pkt_ns, got.last_pkt_ns);
        end
      end
    end
    pending = expected_rsp_q.size();
  end

endmodule

// ===== bench/tb.sv =====
module tb;
  timeunit 1ns;
  timeprecision 1ps;
  import bfmt_pkg::*;
  import flow_tb_pkg::*;

  localparam int RandomItems = 1680;
  localparam int IdleLimit = 20000;
  localparam int ReceiverHold = 3000;

  logic         clk = 1'b0;
  logic         rst_n = 1'b0;
  logic         in_tvalid = 1'b0;
  logic         in_tready;
  logic [215:0] in_tdata = '0;
  logic         out_tvalid;
  logic         out_tready = 1'b0;
  logic [423:0] out_tdata;
  int           fail_count;
  int           pending;
  int           idle_cycles = 0;
  int           rsp_seen = 0;

  // flows the stimulus believes exist, in the order they were sent
  flow_req_t    known_flows[$];

  always #1 clk = ~clk;

  bidirectional_flow_meter_table u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata)
  );

  flow_meter_checker u_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .fail_count(fail_count),
    .pending   (pending)
  );

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 65) return 0;
    if (r < 95) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  // one request transfer, preceded by a random idle gap that may be empty
  task automatic send_req(flow_req_t r);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata <= r;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
  endtask

  function automatic flow_req_t tracked_pkt(action_t act);
    flow_req_t r;
    r = '0;
    r.action = act;
    r.headers_ok = 1'b1;
    r.ether_type = EtherIpv4;
    r.ip_protocol = $urandom_range(0, 1) ? ProtoTcp : ProtoUdp;
    r.pkt_src_ip = $urandom;
    r.pkt_dst_ip = $urandom;
    r.pkt_src_port = 16'($urandom);
    r.pkt_dst_port = 16'($urandom);
    r.packet_length = ($urandom_range(0, 9) == 0) ? 16'hffff :
                      16'($urandom_range(0, 1500));
    r.now_ns = {$urandom, $urandom};
    r.read_slot = 10'($urandom);
    return r;
  endfunction

  // reply packet of a known flow: ends swapped
  function automatic flow_req_t reply_of(flow_req_t f);
    flow_req_t r;
    r = tracked_pkt(ACT_INGRESS);
    r.ip_protocol = f.ip_protocol;
    r.pkt_src_ip = f.pkt_dst_ip;
    r.pkt_dst_ip = f.pkt_src_ip;
    r.pkt_src_port = f.pkt_dst_port;
    r.pkt_dst_port = f.pkt_src_port;
    return r;
  endfunction

  function automatic flow_req_t repeat_of(flow_req_t f);
    flow_req_t r;
    r = tracked_pkt(ACT_EGRESS);
    r.ip_protocol = f.ip_protocol;
    r.pkt_src_ip = f.pkt_src_ip;
    r.pkt_dst_ip = f.pkt_dst_ip;
    r.pkt_src_port = f.pkt_src_port;
    r.pkt_dst_port = f.pkt_dst_port;
    return r;
  endfunction

  task automatic send_new_flow(flow_req_t r);
    if (known_flows.size() < FlowSlots) known_flows.push_back(r);
    send_req(r);
  endtask

  task automatic send_random_item();
    flow_req_t r;
    int c;
    c = $urandom_range(0, 99);
    if (c < 8) begin
      // noise: any field value, mostly filtered
      r = tracked_pkt(action_t'($urandom_range(0, 3)));
      r.headers_ok = 1'($urandom);
      if ($urandom_range(0, 1)) r.ether_type = 16'($urandom);
      if ($urandom_range(0, 1)) r.ip_protocol = 8'($urandom);
      send_req(r);
    end else if (c < 16) begin
      r = tracked_pkt(ACT_READ);
      if (known_flows.size() > 0 && $urandom_range(0, 1))
        r.read_slot = 10'($urandom_range(0, known_flows.size() - 1));
      send_req(r);
    end else if (c < 30) begin
      if (known_flows.size() > 0 && $urandom_range(0, 9) < 7)
        r = reply_of(known_flows[$urandom_range(0, known_flows.size() - 1)]);
      else
        r = tracked_pkt(ACT_INGRESS);
      send_req(r);
    end else begin
      if (known_flows.size() < FlowSlots && $urandom_range(0, 99) < 93)
        send_new_flow(tracked_pkt(ACT_EGRESS));
      else if (known_flows.size() > 0 && $urandom_range(0, 1))
        send_req(repeat_of(known_flows[$urandom_range(0, known_flows.size() - 1)]));
      else
        send_new_flow(tracked_pkt(ACT_EGRESS));
    end
  endtask

  // receiver: random stalls, one long hold-off early in the run
  initial begin
    int gap;
    bit held;
    held = 1'b0;
    @(posedge rst_n);
    forever begin
      gap = pick_gap();
      if (!held && rsp_seen == 40) begin
        gap = ReceiverHold;
        held = 1'b1;
      end
      if (gap > 0) begin
        out_tready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      out_tready <= 1'b1;
      @(posedge clk);
      while (!out_tvalid) @(posedge clk);
      rsp_seen++;
    end
  end

  // watchdog on cycles without any transfer
  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
      idle_cycles <= 0;
    end else if (rst_n) begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IdleLimit) begin
        $display("bidirectional_flow_meter_table test failed");
        $finish;
      end
    end
  end

  // stimulus and verdict
  initial begin
    flow_req_t r;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // reads of an empty table at both ends
    r = tracked_pkt(ACT_READ);
    r.read_slot = 10'd0;
    send_req(r);
    r.read_slot = 10'h3ff;
    send_req(r);
    // filtered packets: each tracking condition broken at least once
    r = tracked_pkt(ACT_EGRESS);
    r.headers_ok = 1'b0;
    send_req(r);
    r = tracked_pkt(ACT_EGRESS);
    r.ether_type = 16'h86dd;
    send_req(r);
    r = tracked_pkt(ACT_INGRESS);
    r.ip_protocol = 8'd0;
    send_req(r);
    r = tracked_pkt(ACT_EGRESS);
    r.ip_protocol = 8'hff;
    send_req(r);
    // undefined action on an otherwise trackable packet
    send_req(tracked_pkt(ACT_NONE));
    // new flow with all-ones key and maxima
    r = tracked_pkt(ACT_EGRESS);
    r.ip_protocol = ProtoTcp;
    r.pkt_src_ip = '1;
    r.pkt_dst_ip = '1;
    r.pkt_src_port = '1;
    r.pkt_dst_port = '1;
    r.packet_length = '1;
    r.now_ns = '1;
    send_new_flow(r);
    // new flow with all-zero key
    r = tracked_pkt(ACT_EGRESS);
    r.ip_protocol = ProtoUdp;
    r.pkt_src_ip = '0;
    r.pkt_dst_ip = '0;
    r.pkt_src_port = '0;
    r.pkt_dst_port = '0;
    r.packet_length = '0;
    r.now_ns = '0;
    send_new_flow(r);
    // asymmetric key so a swap error shows
    send_new_flow(tracked_pkt(ACT_EGRESS));
    send_req(repeat_of(known_flows[0]));
    r = repeat_of(known_flows[1]);
    r.packet_length = '0;
    send_req(r);
    send_req(reply_of(known_flows[2]));
    send_req(reply_of(known_flows[0]));
    // ingress in egress orientation misses
    r = repeat_of(known_flows[2]);
    r.action = ACT_INGRESS;
    send_req(r);
    send_req(tracked_pkt(ACT_INGRESS));
    for (int i = 0; i < 3; i++) begin
      r = tracked_pkt(ACT_READ);
      r.read_slot = 10'(i);
      send_req(r);
    end
    r.read_slot = 10'd3;
    send_req(r);

    for (int n = 0; n < RandomItems; n++) begin
      // sender pause: let the block drain completely once
      if (n == 900) begin
        in_tvalid <= 1'b0;
        @(posedge clk);
        while (pending != 0) @(posedge clk);
      end
      send_random_item();
    end
    in_tvalid <= 1'b0;

    while (pending != 0) @(posedge clk);
    repeat (50) @(posedge clk);
    if (fail_count == 0)
      $display("bidirectional_flow_meter_table test passed");
    else
      $display("bidirectional_flow_meter_table test failed");
    $finish;
  end

endmodule
